>>> sv/wmm_pkg.sv
// wmm_pkg: shared constants, types and helper functions of the window max/min filter
// no dependencies; imported by the interfaces and every module of the block

package wmm_pkg;

    // pixel and window geometry
    localparam int PIX_W      = 8;
    localparam int WINDOW     = 3;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RAD        = WINDOW / 2;
    localparam int ROWS_KEPT  = 2 * RAD + 1;
    localparam int BANK_W     = $clog2(ROWS_KEPT);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LEAD_W     = $clog2(RAD * MAX_WIDTH + RAD + 1);

    // configuration port
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int RESET_DIM  = 128;

    // result queue, depth a power of two so the pointers wrap by themselves
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int PEND_W     = FIFO_AW + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = CFG_IDX_W'(0),
        REG_IMAGE_HEIGHT = CFG_IDX_W'(1)
    } t_cfg_reg;

    // one column of the window, index ROWS_KEPT-1 is the newest row
    typedef logic [ROWS_KEPT-1:0][PIX_W-1:0] t_col;

    // control travelling with an item from the line store to the window stage
    typedef struct packed {
        logic              valid;
        logic              emit;
        logic              border;
        logic              last;
        logic [BANK_W-1:0] bank;
        logic [PIX_W-1:0]  pixel;
    } t_s1_ctrl;

    // one finished result
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] range_value;
        logic             last_of_frame;
    } t_result;

    // last index of a dimension: zero counts as one, large values saturate
    function automatic int unsigned f_dim_last(input logic [CFG_W-1:0] v,
                                               input int unsigned max_dim);
        int unsigned dim;
        dim = 32'(v);
        if (dim == 0) begin
            return 0;
        end
        if (dim > max_dim) begin
            return max_dim - 1;
        end
        return dim - 1;
    endfunction

    // items between a pixel entering and its result leaving
    function automatic int unsigned f_delay(input int unsigned last);
        return RAD * (last + 1) + RAD;
    endfunction

endpackage

>>> sv/wmm_if.sv
// wmm_if: handshake channels of the window max/min filter (pixel, result, config)
// depends on wmm_pkg

interface wmm_pix_if
    import wmm_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output kind, output pixel_value, input ready);
    modport sink   (input valid, input kind, input pixel_value, output ready);
endinterface

interface wmm_res_if
    import wmm_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] range_value;
    logic             last_of_frame;

    modport source (output valid, output range_value, output last_of_frame, input ready);
    modport sink   (input valid, input range_value, input last_of_frame, output ready);
endinterface

interface wmm_cfg_if
    import wmm_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/window_max_min_filter.sv
// window_max_min_filter: local range (max minus min) of a square window over a gray frame
// depends on wmm_pkg, wmm_if, wmm_line_store and wmm_window
//
//  channel   direction  fields                    accepted when
//  i_pix     in         kind, pixel_value         i_pix.valid && i_pix.ready
//  o_res     out        range_value, last_of_frame o_res.valid && o_res.ready
//  i_cfg     in         index, data               i_cfg.valid && i_cfg.ready (ready tied high)
//
//  one item per clock while i_pix.ready is high; a result passes the bank read and column registers into the queue
//  pipeline: counters and bank write/read, column extremes, window extremes into the queue
//  an eight-entry result queue with a pending count keeps i_pix.ready off o_res.ready
//  i_pix.ready drops only when eight results are pending
//  synchronous reset restores 128 x 128 and restarts the frame; row banks are not cleared

module window_max_min_filter
    import wmm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    wmm_pix_if.sink       i_pix,
    wmm_res_if.source     o_res,
    wmm_cfg_if.sink       i_cfg
);

    // configuration derived values
    logic [COL_W-1:0]   r_wlast,  n_wlast;
    logic [ROW_W-1:0]   r_hlast,  n_hlast;
    logic [LEAD_W-1:0]  r_delay,  n_delay;

    // input and output positions
    logic [COL_W-1:0]   r_col,    n_col;
    logic [ROW_W-1:0]   r_row,    n_row;
    logic [BANK_W-1:0]  r_bank,   n_bank;
    logic               r_in_done, n_in_done;
    logic [LEAD_W-1:0]  r_lead,   n_lead;
    logic [ROW_W-1:0]   r_oi,     n_oi;
    logic [COL_W-1:0]   r_oj,     n_oj;

    // result queue
    logic [PIX_W:0]     r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [PEND_W-1:0]  r_count;
    logic [PEND_W-1:0]  r_pending;

    logic               w_acc;
    logic               w_drop;
    logic               w_step;
    logic               w_wr;
    logic               w_emit;
    logic               w_col_wrap;
    logic               w_last;
    logic               w_border;
    logic [ROW_W:0]     w_oi_far;
    logic [COL_W:0]     w_oj_far;
    logic               w_push;
    logic               w_pop;
    t_s1_ctrl           w_s0;
    t_s1_ctrl           w_s1;
    t_col               w_rd;
    t_result            w_res;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = r_pending < PEND_W'(FIFO_DEPTH);
    assign w_acc       = i_pix.valid && i_pix.ready;

    // decode of an accepted item
    assign w_drop     = i_pix.kind && !r_in_done;
    assign w_step     = w_acc && !w_drop;
    assign w_wr       = w_step && !r_in_done;
    assign w_emit     = w_step && (r_lead == '0);
    assign w_col_wrap = r_col == r_wlast;
    assign w_last     = (r_oi == r_hlast) && (r_oj == r_wlast);
    assign w_oi_far   = {1'b0, r_oi} + (ROW_W+1)'(RAD);
    assign w_oj_far   = {1'b0, r_oj} + (COL_W+1)'(RAD);
    assign w_border   = (r_oi < ROW_W'(RAD)) || (w_oi_far > {1'b0, r_hlast}) ||
                        (r_oj < COL_W'(RAD)) || (w_oj_far > {1'b0, r_wlast});

    // next state of the position counters and configuration
    always_comb begin
        n_wlast   = r_wlast;
        n_hlast   = r_hlast;
        n_delay   = r_delay;
        n_col     = r_col;
        n_row     = r_row;
        n_bank    = r_bank;
        n_in_done = r_in_done;
        n_lead    = r_lead;
        n_oi      = r_oi;
        n_oj      = r_oj;

        if (w_step) begin
            // input position, bank follows the row modulo the ring size
            if (w_col_wrap) begin
                n_col  = '0;
                n_bank = (r_bank == BANK_W'(ROWS_KEPT - 1)) ? '0 : r_bank + 1'b1;
                if (!r_in_done) begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
            if (w_wr && w_col_wrap && (r_row == r_hlast)) begin
                n_in_done = 1'b1;
            end

            // output position, frame restarts after its final result
            if (!w_emit) begin
                n_lead = r_lead - 1'b1;
            end else if (w_last) begin
                n_col     = '0;
                n_row     = '0;
                n_bank    = '0;
                n_in_done = 1'b0;
                n_lead    = r_delay;
                n_oi      = '0;
                n_oj      = '0;
            end else if (r_oj == r_wlast) begin
                n_oj = '0;
                n_oi = r_oi + 1'b1;
            end else begin
                n_oj = r_oj + 1'b1;
            end
        end

        // a width or height register write restarts the frame, stored rows are kept
        if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_IMAGE_WIDTH: begin
                    n_wlast = COL_W'(f_dim_last(i_cfg.data, MAX_WIDTH));
                    n_delay = LEAD_W'(f_delay(f_dim_last(i_cfg.data, MAX_WIDTH)));
                end
                REG_IMAGE_HEIGHT: begin
                    n_hlast = ROW_W'(f_dim_last(i_cfg.data, MAX_HEIGHT));
                end
                default: begin
                end
            endcase
            if ((t_cfg_reg'(i_cfg.index) == REG_IMAGE_WIDTH) ||
                (t_cfg_reg'(i_cfg.index) == REG_IMAGE_HEIGHT)) begin
                n_col     = '0;
                n_row     = '0;
                n_bank    = '0;
                n_in_done = 1'b0;
                n_lead    = n_delay;
                n_oi      = '0;
                n_oj      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast   <= COL_W'(f_dim_last(CFG_W'(RESET_DIM), MAX_WIDTH));
            r_hlast   <= ROW_W'(f_dim_last(CFG_W'(RESET_DIM), MAX_HEIGHT));
            r_delay   <= LEAD_W'(f_delay(f_dim_last(CFG_W'(RESET_DIM), MAX_WIDTH)));
            r_col     <= '0;
            r_row     <= '0;
            r_bank    <= '0;
            r_in_done <= 1'b0;
            r_lead    <= LEAD_W'(f_delay(f_dim_last(CFG_W'(RESET_DIM), MAX_WIDTH)));
            r_oi      <= '0;
            r_oj      <= '0;
        end else begin
            r_wlast   <= n_wlast;
            r_hlast   <= n_hlast;
            r_delay   <= n_delay;
            r_col     <= n_col;
            r_row     <= n_row;
            r_bank    <= n_bank;
            r_in_done <= n_in_done;
            r_lead    <= n_lead;
            r_oi      <= n_oi;
            r_oj      <= n_oj;
        end
    end

    // item control into the pipeline
    always_comb begin
        w_s0.valid  = w_step;
        w_s0.emit   = w_emit;
        w_s0.border = w_border;
        w_s0.last   = w_last;
        w_s0.bank   = r_bank;
        w_s0.pixel  = i_pix.pixel_value;
    end

    wmm_line_store u_line_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_s0),
        .i_wr_en (w_wr),
        .i_col   (r_col),
        .o_ctrl  (w_s1),
        .o_rd    (w_rd)
    );

    wmm_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_s1),
        .i_rd    (w_rd),
        .o_res   (w_res)
    );

    // result queue
    assign w_push = w_res.valid;
    assign w_pop  = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= {w_res.range_value, w_res.last_of_frame};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
            r_pending <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count   <= r_count + PEND_W'(w_push) - PEND_W'(w_pop);
            r_pending <= r_pending + PEND_W'(w_emit) - PEND_W'(w_pop);
        end
    end

    assign o_res.valid         = r_count != '0;
    assign o_res.range_value   = r_fifo[r_rd_ptr][PIX_W:1];
    assign o_res.last_of_frame = r_fifo[r_rd_ptr][0];

`ifndef NO_ASSERTIONS
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(FIFO_DEPTH))
        else $error("pending results exceed queue depth");

    a_queue_within_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_pending)
        else $error("queue holds more results than are pending");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_count < PEND_W'(FIFO_DEPTH)) || w_pop)
        else $error("result pushed into a full queue");

    a_emit_needs_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> r_lead == '0 && !w_drop)
        else $error("result issued before the window delay elapsed");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last && !i_cfg.valid) |=> (r_oi == '0) && (r_oj == '0) && !r_in_done)
        else $error("frame did not restart after its final result");
`endif

endmodule

>>> sv/wmm_line_store.sv
// wmm_line_store: ring of row banks, one memory per kept row, with registered reads
// depends on wmm_pkg; feeds wmm_window

module wmm_line_store
    import wmm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_s1_ctrl         i_ctrl,
    input  logic             i_wr_en,
    input  logic [COL_W-1:0] i_col,
    output t_s1_ctrl         o_ctrl,
    output t_col             o_rd
);

    // one bank per row of the ring, all read at the same column
    for (genvar k = 0; k < ROWS_KEPT; k++) begin : g_bank
        logic [PIX_W-1:0] r_mem [MAX_WIDTH];

        always_ff @(posedge i_clk) begin
            if (i_wr_en && (i_ctrl.bank == BANK_W'(k))) begin
                r_mem[i_col] <= i_ctrl.pixel;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctrl.valid) begin
                o_rd[k] <= r_mem[i_col];
            end
        end
    end

    // control is registered alongside the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl <= '0;
        end else begin
            o_ctrl <= i_ctrl;
        end
    end

endmodule

>>> sv/wmm_window.sv
// wmm_window: column max/min, sliding window of column extremes, range and border mux
// depends on wmm_pkg; takes the registered columns of wmm_line_store

module wmm_window
    import wmm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_s1_ctrl i_ctrl,
    input  t_col     i_rd,
    output t_result  o_res
);

    t_col                             w_col;
    logic [PIX_W-1:0]                 n_cmax;
    logic [PIX_W-1:0]                 n_cmin;
    logic [ROWS_KEPT-1:0][PIX_W-1:0]  r_cmax;
    logic [ROWS_KEPT-1:0][PIX_W-1:0]  r_cmin;
    logic                             r_push;
    logic                             r_border;
    logic                             r_last;
    logic [PIX_W-1:0]                 w_wmax;
    logic [PIX_W-1:0]                 w_wmin;

    // gather the column: older rows from the banks, newest row from the item itself
    always_comb begin
        logic [BANK_W:0] v_sel;
        v_sel = '0;
        for (int m = 0; m < ROWS_KEPT - 1; m++) begin
            v_sel = {1'b0, i_ctrl.bank} + (BANK_W+1)'(m + 1);
            if (v_sel >= (BANK_W+1)'(ROWS_KEPT)) begin
                v_sel = v_sel - (BANK_W+1)'(ROWS_KEPT);
            end
            w_col[m] = i_rd[v_sel[BANK_W-1:0]];
        end
        w_col[ROWS_KEPT-1] = i_ctrl.pixel;
    end

    // extremes of the new column
    always_comb begin
        n_cmax = w_col[0];
        n_cmin = w_col[0];
        for (int m = 1; m < ROWS_KEPT; m++) begin
            if (w_col[m] > n_cmax) begin
                n_cmax = w_col[m];
            end
            if (w_col[m] < n_cmin) begin
                n_cmin = w_col[m];
            end
        end
    end

    // shift line of column extremes, index 0 is the oldest column
    always_ff @(posedge i_clk) begin
        if (i_ctrl.valid) begin
            r_cmax <= {n_cmax, r_cmax[ROWS_KEPT-1:1]};
            r_cmin <= {n_cmin, r_cmin[ROWS_KEPT-1:1]};
        end
        r_border <= i_ctrl.border;
        r_last   <= i_ctrl.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push <= 1'b0;
        end else begin
            r_push <= i_ctrl.valid && i_ctrl.emit;
        end
    end

    // window extremes over the stored columns
    always_comb begin
        w_wmax = r_cmax[0];
        w_wmin = r_cmin[0];
        for (int n = 1; n < ROWS_KEPT; n++) begin
            if (r_cmax[n] > w_wmax) begin
                w_wmax = r_cmax[n];
            end
            if (r_cmin[n] < w_wmin) begin
                w_wmin = r_cmin[n];
            end
        end
    end

    // range, forced to zero for a border centre
    always_comb begin
        o_res.valid         = r_push;
        o_res.range_value   = r_border ? '0 : (w_wmax - w_wmin);
        o_res.last_of_frame = r_last;
    end

endmodule
